FILE: rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// Back-face cull package
// Constants shared by the top level and the normalization lane.
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int M_BITS   = 31;
    localparam int S_BITS   = 2 * M_BITS + 2;
    localparam int IDX_BITS = 2;

    localparam logic [IDX_BITS-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_CAMERA_Z = 2'd2;

endpackage

FILE: rtl/bfc_lane.sv
// ----------------------------------------------------------------------------
// Back-face cull normalization lane
// Pipelined restoring divide of m^2 * 2^(2F+2) by the squared length, then a
// pipelined integer square root, giving one rounded unit-normal magnitude.
// ----------------------------------------------------------------------------
module bfc_lane #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [2*bfc_pkg::M_BITS-1:0]         i_m2,
    input  logic [bfc_pkg::S_BITS-1:0]           i_s,
    output logic [NORMAL_FRAC_BITS:0]            o_q
);
    import bfc_pkg::*;

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int YW = 2 * F + 3;
    localparam int RW = F + 2;
    localparam int DW = S_BITS + YW;
    localparam int XW = 2 * M_BITS + 2 * F + 2;

    logic [DW-1:0]     r_div [0:YW];
    logic [S_BITS-1:0] r_dvs [0:YW];
    logic [RW-1:0]     r_root [1:RW];
    logic [YW-1:0]     r_rad  [1:RW];

    logic [XW-1:0] w_x;
    assign w_x = {i_m2, {(2 * F + 2){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0] <= DW'(w_x);
            r_dvs[0] <= i_s;
        end
    end

    for (genvar k = 1; k <= YW; k++) begin : g_div
        logic [DW:0]       w_sh;
        logic [S_BITS:0]   w_top;
        logic              w_ge;
        logic [S_BITS:0]   w_rem;
        assign w_sh  = {r_div[k-1], 1'b0};
        assign w_top = w_sh[DW:YW];
        assign w_ge  = w_top >= {1'b0, r_dvs[k-1]};
        assign w_rem = w_ge ? (w_top - {1'b0, r_dvs[k-1]}) : w_top;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[k] <= {w_rem[S_BITS-1:0], w_sh[YW-1:1], w_ge};
                r_dvs[k] <= r_dvs[k-1];
            end
        end
    end

    for (genvar j = 1; j <= RW; j++) begin : g_sqrt
        logic [RW-1:0]   w_prev;
        logic [YW-1:0]   w_y;
        logic [RW-1:0]   w_cand;
        logic [2*RW-1:0] w_sq;
        if (j == 1) begin : g_first
            assign w_prev = '0;
            assign w_y    = r_div[YW][YW-1:0];
        end else begin : g_rest
            assign w_prev = r_root[j-1];
            assign w_y    = r_rad[j-1];
        end
        assign w_cand = w_prev | (RW'(1) << (RW - j));
        assign w_sq   = (2*RW)'(w_cand) * (2*RW)'(w_cand);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= (w_sq <= (2*RW)'(w_y)) ? w_cand : w_prev;
                r_rad[j]  <= w_y;
            end
        end
    end

    logic [RW:0] w_rp1;
    assign w_rp1 = {1'b0, r_root[RW]} + (RW+1)'(1);
    assign o_q   = w_rp1[F+1:1];

endmodule

FILE: rtl/backface_cull_face_normal_top.sv
// ----------------------------------------------------------------------------
// Back-face cull by face normal
// Triangle edges, cross product, unit normal and eye-vector sign test.
// ----------------------------------------------------------------------------
// The block takes one triangle word per cycle and returns one result word per
// triangle once it has passed the per-bit divide and square-root stages of the
// normalization lanes. A stall on the output freezes the whole pipeline;
// otherwise a word may enter every cycle.
module backface_cull_face_normal_top #(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_v0_x,
    input  logic signed [COORD_WIDTH-1:0]       i_v0_y,
    input  logic signed [COORD_WIDTH-1:0]       i_v0_z,
    input  logic signed [COORD_WIDTH-1:0]       i_v1_x,
    input  logic signed [COORD_WIDTH-1:0]       i_v1_y,
    input  logic signed [COORD_WIDTH-1:0]       i_v1_z,
    input  logic signed [COORD_WIDTH-1:0]       i_v2_x,
    input  logic signed [COORD_WIDTH-1:0]       i_v2_y,
    input  logic signed [COORD_WIDTH-1:0]       i_v2_z,
    input  logic                                i_cfg_we,
    input  logic [bfc_pkg::IDX_BITS-1:0]        i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]              i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_z,
    output logic                                o_back_facing
);
    import bfc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int AW   = CW + 1;
    localparam int PW   = 2 * AW;
    localparam int MW   = PW + 1;
    localparam int SHW  = $clog2(MW + 1);
    localparam int NW   = F + 2;
    localparam int PRW  = NW + AW;
    localparam int DOTW = PRW + 2;
    localparam int LAT  = 3 * F + 6;
    localparam int NV   = 7 + LAT + 3;
    localparam int SBW  = 4 + 3 * AW;

    logic en;
    logic [NV-1:0] r_vld;

    assign en      = !r_vld[NV-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    logic signed [CW-1:0] r_cam [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0] <= '0;
            r_cam[1] <= '0;
            r_cam[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAMERA_X: r_cam[0] <= i_cfg_data;
                REG_CAMERA_Y: r_cam[1] <= i_cfg_data;
                REG_CAMERA_Z: r_cam[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] w_v0 [3];
    logic signed [CW-1:0] w_v1 [3];
    logic signed [CW-1:0] w_v2 [3];
    assign w_v0[0] = i_v0_x;
    assign w_v0[1] = i_v0_y;
    assign w_v0[2] = i_v0_z;
    assign w_v1[0] = i_v1_x;
    assign w_v1[1] = i_v1_y;
    assign w_v1[2] = i_v1_z;
    assign w_v2[0] = i_v2_x;
    assign w_v2[1] = i_v2_y;
    assign w_v2[2] = i_v2_z;

    logic signed [AW-1:0] r1_a [3];
    logic signed [AW-1:0] r1_b [3];
    logic signed [AW-1:0] r1_e [3];
    logic signed [PW-1:0] r2_pp [3];
    logic signed [PW-1:0] r2_pm [3];
    logic signed [AW-1:0] r2_e [3];
    logic [MW-1:0]        r3_mag [3];
    logic [2:0]           r3_neg;
    logic signed [AW-1:0] r3_e [3];
    logic [MW-1:0]        r4_mag [3];
    logic [2:0]           r4_neg;
    logic                 r4_zero;
    logic [SHW-1:0]       r4_sh;
    logic signed [AW-1:0] r4_e [3];
    logic [M_BITS-1:0]    r5_m [3];
    logic [SBW-1:0]       r5_sb;
    logic [2*M_BITS-1:0]  r6_m2 [3];
    logic [SBW-1:0]       r6_sb;
    logic [2*M_BITS-1:0]  r7_m2 [3];
    logic [S_BITS-1:0]    r7_s;
    logic [SBW-1:0]       r7_sb;
    logic [SBW-1:0]       r_sb [1:LAT];

    for (genvar i = 0; i < 3; i++) begin : g_front
        logic signed [MW-1:0] w_c;
        logic [MW-1:0]        w_shv;
        assign w_c   = MW'(r2_pp[i]) - MW'(r2_pm[i]);
        assign w_shv = r4_mag[i] << r4_sh;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_a[i]   <= AW'(w_v1[i]) - AW'(w_v0[i]);
                r1_b[i]   <= AW'(w_v2[i]) - AW'(w_v0[i]);
                r1_e[i]   <= AW'(w_v0[i]) - AW'(r_cam[i]);
                r2_pp[i]  <= PW'(r1_a[(i+1)%3]) * PW'(r1_b[(i+2)%3]);
                r2_pm[i]  <= PW'(r1_a[(i+2)%3]) * PW'(r1_b[(i+1)%3]);
                r2_e[i]   <= r1_e[i];
                r3_mag[i] <= w_c[MW-1] ? MW'(-w_c) : MW'(w_c);
                r3_neg[i] <= w_c[MW-1];
                r3_e[i]   <= r2_e[i];
                r4_mag[i] <= r3_mag[i];
                r4_e[i]   <= r3_e[i];
                r5_m[i]   <= w_shv[MW-1 -: M_BITS];
                r6_m2[i]  <= (2*M_BITS)'(r5_m[i]) * (2*M_BITS)'(r5_m[i]);
                r7_m2[i]  <= r6_m2[i];
            end
        end
    end

    logic [MW-1:0]  w_or;
    logic [SHW-1:0] w_lz;
    assign w_or = r3_mag[0] | r3_mag[1] | r3_mag[2];

    always_comb begin
        w_lz = SHW'(MW);
        for (int k = 0; k < MW; k++) begin
            if (w_or[k]) begin
                w_lz = SHW'(MW - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_neg  <= r3_neg;
            r4_zero <= (w_or == '0);
            r4_sh   <= w_lz;
            r5_sb   <= {r4_neg, r4_zero, r4_e[2], r4_e[1], r4_e[0]};
            r6_sb   <= r5_sb;
            r7_sb   <= r6_sb;
            r7_s    <= S_BITS'(r6_m2[0]) + S_BITS'(r6_m2[1]) + S_BITS'(r6_m2[2]);
            r_sb[1] <= r7_sb;
        end
    end

    for (genvar k = 2; k <= LAT; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    logic [F:0]            w_q [3];
    logic [SBW-1:0]        w_sb;
    logic signed [NW-1:0]  r8_n [3];
    logic signed [AW-1:0]  r8_e [3];
    logic signed [PRW-1:0] r9_prod [3];
    logic signed [NW-1:0]  r9_n [3];
    logic signed [DOTW-1:0] w_dot;

    assign w_sb = r_sb[LAT];

    for (genvar i = 0; i < 3; i++) begin : g_back
        bfc_lane #(
            .NORMAL_FRAC_BITS(F)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_m2  (r7_m2[i]),
            .i_s   (r7_s),
            .o_q   (w_q[i])
        );

        logic signed [NW-1:0] w_qs;
        assign w_qs = signed'(NW'(w_q[i]));

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (w_sb[3*AW]) begin
                    r8_n[i] <= '0;
                end else if (w_sb[3*AW+1+i]) begin
                    r8_n[i] <= -w_qs;
                end else begin
                    r8_n[i] <= w_qs;
                end
                r8_e[i]    <= w_sb[i*AW +: AW];
                r9_prod[i] <= PRW'(r8_n[i]) * PRW'(r8_e[i]);
                r9_n[i]    <= r8_n[i];
            end
        end
    end

    assign w_dot = DOTW'(r9_prod[0]) + DOTW'(r9_prod[1]) + DOTW'(r9_prod[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_normal_x    <= r9_n[0];
            o_normal_y    <= r9_n[1];
            o_normal_z    <= r9_n[2];
            o_back_facing <= w_dot[DOTW-1];
        end
    end

endmodule
